[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define AAS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define AAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/aas_pkg.sv]
// Shared constants, codes and helpers of the area average image scaler
`default_nettype none
package aas_pkg;
   // default frame limits
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // field widths
   localparam int KIND_W  = 1;
   localparam int ADDR_W  = 16;
   localparam int PIX_W   = 32;
   localparam int COORD_W = 8;
   localparam int COLOR_W = 24;
   localparam int ALPHA_W = 8;
   localparam int DIM_W   = 9;
   localparam int ZOOM_W  = 9;
   localparam int FMT_W   = 2;
   localparam int CH_W    = 8;

   localparam int STORE_DEPTH = 65536;

   // datapath widths: box positions, divisor, pixel weight
   localparam int POS_W = 24;
   localparam int DEN_W = 17;
   localparam int W_W   = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER     = 3'd4;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_RGB565A = 2'd0;
   localparam logic [FMT_W-1:0] FMT_BGRA32  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RGB565  = 2'd2;
   localparam logic [FMT_W-1:0] FMT_BGR24   = 2'd3;

   // input word kinds
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   localparam int ZOOM_DIV    = 100;
   localparam int ZOOM_HALF   = 50;
   localparam int SRC_DIM_MAX = 256;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // divide by 100 as multiply by ceil(2^24 / 100) and shift;
   // exact floor for numerators below 199000
   localparam int ZOOM_RECIP   = 167773;
   localparam int ZOOM_RECIP_W = 18;
   localparam int ZOOM_SHIFT   = 24;

   // source dimension forced into 1..256
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(SRC_DIM_MAX)) begin
         r = DIM_W'(SRC_DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/core/aas_req_if.sv]
// Request channel: pixel loads and output pixel requests
`default_nettype none
interface aas_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [aas_pkg::ADDR_W-1:0]  pixel_index;
   logic [aas_pkg::PIX_W-1:0]   src_pixel;
   logic [aas_pkg::COORD_W-1:0] out_x;
   logic [aas_pkg::COORD_W-1:0] out_y;

   modport source(output valid, kind, pixel_index, src_pixel, out_x, out_y, input ready);
   modport sink(input valid, kind, pixel_index, src_pixel, out_x, out_y, output ready);
endinterface
`default_nettype wire

[rtl/core/aas_rsp_if.sv]
// Response channel: one result pixel per request
`default_nettype none
interface aas_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [aas_pkg::COLOR_W-1:0] color_word;
   logic [aas_pkg::ALPHA_W-1:0] alpha;
   logic                        out_of_range;
   logic [aas_pkg::DIM_W-1:0]   result_width;
   logic [aas_pkg::DIM_W-1:0]   result_height;

   modport source(output valid, color_word, alpha, out_of_range, result_width,
                  result_height, input ready);
   modport sink(input valid, color_word, alpha, out_of_range, result_width,
                result_height, output ready);
endinterface
`default_nettype wire

[rtl/core/area_average_image_scaler.sv]
// A load is written to the pixel store when accepted. A request in padding or outside
// the frame returns a blank word once the frame size is known. A request inside the picture
// averages a box of R rows and C columns; nine divisions on the shared one-bit-per-cycle
// divider and the store reads of the box dominate; a stalled output word adds its wait.
// One item at a time. Reset (synchronous) restores the registers to their reset values
// and empties the result stage; the pixel store keeps its contents, no clearing pass.
`default_nettype none
module area_average_image_scaler #(
   parameter int MAX_WIDTH  = aas_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aas_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   aas_req_if.sink                               req_ch,
   aas_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [aas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [aas_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   localparam int P     = aas_pkg::POS_W;
   localparam int DW_W  = $clog2(MAX_WIDTH + 1);
   localparam int DH_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2(P + 1);
   localparam int SHW   = aas_pkg::DIM_W + DW_W;
   localparam int JW    = aas_pkg::COORD_W + DW_W;
   localparam int RBW   = aas_pkg::DIM_W + aas_pkg::COORD_W;
   localparam int NDW   = 2 * aas_pkg::DIM_W;
   localparam int ZQW   = NDW + aas_pkg::ZOOM_RECIP_W;
   localparam int DQW   = ZQW - aas_pkg::ZOOM_SHIFT;
   localparam int PRW   = aas_pkg::CH_W + aas_pkg::W_W;
   localparam int DIMW  = aas_pkg::DIM_W;
   localparam int CW    = aas_pkg::CH_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DW, S_DWQ, S_DH, S_DHQ, S_CHECK, S_B0, S_B1, S_B2, S_B3, S_B4,
      S_ROW, S_ROWB, S_COLA, S_COLB, S_COLC, S_CH, S_CHQ, S_PACK, S_DONE, S_DIV
   } state_type;

   state_type state_ff, ret_ff;

   // configuration registers
   logic [DIMW-1:0]                 src_width_ff, src_height_ff;
   logic [aas_pkg::ZOOM_W-1:0]      zoom_ff;
   logic [aas_pkg::FMT_W-1:0]       fmt_ff;
   logic                            center_ff;

   // request and geometry
   logic [aas_pkg::COORD_W-1:0]     qx_ff, qy_ff;
   logic [NDW-1:0]                  ndw_ff;
   logic [DW_W-1:0]                 dw_ff;
   logic [DH_W-1:0]                 dh_ff;
   logic [P-1:0]                    lox_ff, hix_ff, loy_ff, hiy_ff, a_ff, c_ff;
   logic [7:0]                      i_ff, i0_ff, i1_ff, j_ff, j0_ff, j1_ff;
   logic [aas_pkg::ADDR_W-1:0]      rowbase_ff, addr_ff;
   logic [DIMW-1:0]                 oy_ff;
   logic [aas_pkg::W_W-1:0]         w_ff;
   logic [P-1:0]                    acc_ff [4];
   logic [CW-1:0]                   ch_ff [4];
   logic [1:0]                      k_ff;

   // divider
   logic [aas_pkg::DEN_W-1:0]       div_rem_ff, div_den_ff;
   logic [P-1:0]                    div_quo_ff;
   logic [CNT_W-1:0]                div_cnt_ff;
   logic [aas_pkg::DEN_W:0]         div_trial;
   logic                            div_ge;
   logic [aas_pkg::DEN_W-1:0]       div_rem_in;
   logic                            div_go;
   logic [P-1:0]                    div_num;
   logic [aas_pkg::DEN_W-1:0]       div_dvs;
   state_type                       div_ret;

   // result staging and output register
   logic [aas_pkg::COLOR_W-1:0]     res_color_ff, rsp_color_ff;
   logic [aas_pkg::ALPHA_W-1:0]     res_alpha_ff, rsp_alpha_ff;
   logic                            res_oor_ff, rsp_oor_ff;
   logic [DIMW-1:0]                 res_fw_ff, res_fh_ff, rsp_fw_ff, rsp_fh_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_load;

   // store
   logic                            mem_wr;
   logic [aas_pkg::PIX_W-1:0]       mem_rd;

   // combinational datapath
   logic [DIMW-1:0]                 sw, sh;
   logic [P-1:0]                    sw_p, sh_p, dw_p, dh_p, fw_p, fh_p, offx_p, offy_p;
   logic [P-1:0]                    qx_p, qy_p, px_p, py_p;
   logic                            centered, oor, pad;
   logic [RBW-1:0]                  lox_prod, loy_prod, rowbase_prod;
   logic [NDW-1:0]                  ndw;
   logic [ZQW-1:0]                  zq_prod;
   logic [DQW-1:0]                  dw_q;
   logic [SHW-1:0]                  shdw;
   logic [JW-1:0]                   a_prod, c_prod;
   logic [P-1:0]                    b_p, d_p, oy_hi, oy_lo, oy_p, ox_hi, ox_lo, ox_p;
   logic [aas_pkg::DEN_W-1:0]       den;
   logic [DW_W-1:0]                 dw_in;
   logic [DH_W-1:0]                 dh_in;
   logic [CW-1:0]                   v [4];
   logic [PRW-1:0]                  prod [4];
   logic [aas_pkg::COLOR_W-1:0]     color_in;
   logic [aas_pkg::ALPHA_W-1:0]     alpha_in;
   logic                            req_acc;

   aas_ram #(
      .WIDTH(aas_pkg::PIX_W),
      .DEPTH(aas_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(req_ch.pixel_index),
      .wr_data(req_ch.src_pixel),
      .rd_addr(addr_ff),
      .rd_data(mem_rd)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign mem_wr       = req_acc && (req_ch.kind == aas_pkg::KIND_LOAD);

   // frame geometry
   assign sw       = aas_pkg::clamp_dim(src_width_ff);
   assign sh       = aas_pkg::clamp_dim(src_height_ff);
   assign sw_p     = P'(sw);
   assign sh_p     = P'(sh);
   assign dw_p     = P'(dw_ff);
   assign dh_p     = P'(dh_ff);
   assign centered = center_ff && (sw_p > dw_p);
   assign fw_p     = centered ? sw_p : dw_p;
   assign fh_p     = centered ? sh_p : dh_p;
   assign offx_p   = centered ? ((sw_p - dw_p) >> 1) : '0;
   assign offy_p   = centered ? ((sh_p - dh_p) >> 1) : '0;
   assign qx_p     = P'(qx_ff);
   assign qy_p     = P'(qy_ff);
   assign px_p     = qx_p - offx_p;
   assign py_p     = qy_p - offy_p;
   assign oor      = (qx_p >= fw_p) || (qy_p >= fh_p);
   assign pad      = (qx_p < offx_p) || (qy_p < offy_p) || (px_p >= dw_p) || (py_p >= dh_p);

   assign ndw      = NDW'(sw) * NDW'(zoom_ff) + NDW'(aas_pkg::ZOOM_HALF);
   assign shdw     = SHW'(sh) * SHW'(dw_ff);
   assign lox_prod = RBW'(px_p[7:0]) * RBW'(sw);
   assign loy_prod = RBW'(py_p[7:0]) * RBW'(sw);
   assign den      = aas_pkg::DEN_W'(sw) * aas_pkg::DEN_W'(sw);

   // rounded width: registered numerator times the reciprocal of 100
   assign zq_prod = ZQW'(ndw_ff) * ZQW'(aas_pkg::ZOOM_RECIP);
   assign dw_q    = zq_prod[ZQW-1:aas_pkg::ZOOM_SHIFT];

   // width and height clamps
   assign dw_in = (dw_q == '0) ? DW_W'(1) :
                  (P'(dw_q) > P'(MAX_WIDTH)) ? DW_W'(MAX_WIDTH) : dw_q[DW_W-1:0];
   assign dh_in = (div_quo_ff > P'(MAX_HEIGHT)) ? DH_W'(MAX_HEIGHT) : div_quo_ff[DH_W-1:0];

   // row and column overlaps in units of 1/dw
   assign a_prod       = JW'(j_ff) * JW'(dw_ff);
   assign rowbase_prod = RBW'(j_ff) * RBW'(sw);
   assign c_prod       = JW'(i_ff) * JW'(dw_ff);
   assign b_p   = a_ff + dw_p;
   assign oy_hi = (hiy_ff < b_p) ? hiy_ff : b_p;
   assign oy_lo = (loy_ff > a_ff) ? loy_ff : a_ff;
   assign oy_p  = oy_hi - oy_lo;
   assign d_p   = c_ff + dw_p;
   assign ox_hi = (hix_ff < d_p) ? hix_ff : d_p;
   assign ox_lo = (lox_ff > c_ff) ? lox_ff : c_ff;
   assign ox_p  = ox_hi - ox_lo;

   // decode the stored word into four channels
   always_comb begin
      if (fmt_ff == aas_pkg::FMT_RGB565A || fmt_ff == aas_pkg::FMT_RGB565) begin
         v[0] = {3'b000, mem_rd[4:0]};
         v[1] = {2'b00, mem_rd[10:8], mem_rd[7:5]};
         v[2] = {3'b000, mem_rd[15:11]};
         v[3] = (fmt_ff == aas_pkg::FMT_RGB565A) ? mem_rd[23:16] : aas_pkg::ALPHA_OPAQUE;
      end else begin
         v[0] = mem_rd[7:0];
         v[1] = mem_rd[15:8];
         v[2] = mem_rd[23:16];
         v[3] = (fmt_ff == aas_pkg::FMT_BGRA32) ? mem_rd[31:24] : aas_pkg::ALPHA_OPAQUE;
      end
      for (int n = 0; n < 4; n++) begin
         prod[n] = PRW'(v[n]) * PRW'(w_ff);
      end
   end

   // re-pack the averaged channels
   always_comb begin
      if (fmt_ff == aas_pkg::FMT_RGB565A || fmt_ff == aas_pkg::FMT_RGB565) begin
         color_in = {8'h00, ch_ff[2][4:0], ch_ff[1][5:3], ch_ff[1][2:0], ch_ff[0][4:0]};
      end else begin
         color_in = {ch_ff[2], ch_ff[1], ch_ff[0]};
      end
      alpha_in = (fmt_ff == aas_pkg::FMT_RGB565A || fmt_ff == aas_pkg::FMT_BGRA32) ?
                 ch_ff[3] : aas_pkg::ALPHA_OPAQUE;
   end

   // divider operand selection per state
   always_comb begin
      div_go  = 1'b0;
      div_num = '0;
      div_dvs = '0;
      div_ret = S_IDLE;
      unique case (state_ff)
         S_DH: begin
            div_go = 1'b1; div_num = P'(shdw);
            div_dvs = aas_pkg::DEN_W'(sw); div_ret = S_DHQ;
         end
         S_B0: begin
            div_go = 1'b1; div_num = lox_ff;
            div_dvs = aas_pkg::DEN_W'(dw_ff); div_ret = S_B1;
         end
         S_B1: begin
            div_go = 1'b1; div_num = hix_ff - P'(1);
            div_dvs = aas_pkg::DEN_W'(dw_ff); div_ret = S_B2;
         end
         S_B2: begin
            div_go = 1'b1; div_num = loy_ff;
            div_dvs = aas_pkg::DEN_W'(dw_ff); div_ret = S_B3;
         end
         S_B3: begin
            div_go = 1'b1; div_num = hiy_ff - P'(1);
            div_dvs = aas_pkg::DEN_W'(dw_ff); div_ret = S_B4;
         end
         S_CH: begin
            div_go = 1'b1; div_num = acc_ff[k_ff];
            div_dvs = den; div_ret = S_CHQ;
         end
         default: begin
         end
      endcase
   end

   // restoring divider step
   assign div_trial  = {div_rem_ff, div_quo_ff[P-1]};
   assign div_ge     = (div_trial >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? aas_pkg::DEN_W'(div_trial - {1'b0, div_den_ff}) :
                                div_trial[aas_pkg::DEN_W-1:0];

   // output register takes the staged word once it is free
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // sequencer, divider, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= DIMW'(1);
         src_height_ff <= DIMW'(1);
         zoom_ff       <= aas_pkg::ZOOM_W'(aas_pkg::ZOOM_DIV);
         fmt_ff        <= aas_pkg::FMT_RGB565A;
         center_ff     <= 1'b1;
      end else begin
         // configuration writes
         if (csr_wr_en) begin
            unique case (csr_index)
               aas_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wr_data;
               aas_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wr_data;
               aas_pkg::CSR_ZOOM:       zoom_ff       <= csr_wr_data;
               aas_pkg::CSR_FORMAT:     fmt_ff        <= csr_wr_data[aas_pkg::FMT_W-1:0];
               aas_pkg::CSR_CENTER:     center_ff     <= csr_wr_data[0];
               default: begin
               end
            endcase
         end

         // divider: load or shift one quotient bit
         if (div_go) begin
            div_quo_ff <= div_num;
            div_rem_ff <= '0;
            div_den_ff <= div_dvs;
            div_cnt_ff <= CNT_W'(P);
            ret_ff     <= div_ret;
         end else if (state_ff == S_DIV && div_cnt_ff != '0) begin
            div_quo_ff <= {div_quo_ff[P-2:0], div_ge};
            div_rem_ff <= div_rem_in;
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && req_ch.kind == aas_pkg::KIND_REQUEST) begin
                  qx_ff    <= req_ch.out_x;
                  qy_ff    <= req_ch.out_y;
                  state_ff <= S_DW;
               end
            end
            S_DIV: begin
               if (div_cnt_ff == '0) begin
                  state_ff <= ret_ff;
               end
            end
            S_DW: begin
               ndw_ff   <= ndw;
               state_ff <= S_DWQ;
            end
            S_DWQ: begin
               dw_ff    <= dw_in;
               state_ff <= S_DH;
            end
            S_DH: state_ff <= S_DIV;
            S_DHQ: begin
               dh_ff    <= dh_in;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               res_fw_ff <= fw_p[DIMW-1:0];
               res_fh_ff <= fh_p[DIMW-1:0];
               res_oor_ff <= oor;
               res_color_ff <= '0;
               res_alpha_ff <= '0;
               lox_ff <= P'(lox_prod);
               hix_ff <= P'(lox_prod) + sw_p;
               loy_ff <= P'(loy_prod);
               hiy_ff <= P'(loy_prod) + sw_p;
               if (oor || pad) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_B0;
               end
            end
            S_B0: state_ff <= S_DIV;
            S_B1: begin
               i0_ff    <= div_quo_ff[7:0];
               state_ff <= S_DIV;
            end
            S_B2: begin
               i1_ff    <= div_quo_ff[7:0];
               state_ff <= S_DIV;
            end
            S_B3: begin
               j0_ff    <= div_quo_ff[7:0];
               state_ff <= S_DIV;
            end
            S_B4: begin
               j1_ff    <= div_quo_ff[7:0];
               j_ff     <= j0_ff;
               for (int n = 0; n < 4; n++) begin
                  acc_ff[n] <= '0;
               end
               state_ff <= S_ROW;
            end
            // row start: row edge and store row base
            S_ROW: begin
               a_ff       <= P'(a_prod);
               rowbase_ff <= rowbase_prod[aas_pkg::ADDR_W-1:0];
               i_ff       <= i0_ff;
               state_ff   <= S_ROWB;
            end
            S_ROWB: begin
               oy_ff    <= oy_p[DIMW-1:0];
               state_ff <= S_COLA;
            end
            // column: address, weight, accumulate
            S_COLA: begin
               c_ff     <= P'(c_prod);
               addr_ff  <= rowbase_ff + aas_pkg::ADDR_W'(i_ff);
               state_ff <= S_COLB;
            end
            S_COLB: begin
               w_ff     <= aas_pkg::W_W'(ox_p[DIMW-1:0]) * aas_pkg::W_W'(oy_ff);
               state_ff <= S_COLC;
            end
            S_COLC: begin
               for (int n = 0; n < 4; n++) begin
                  acc_ff[n] <= acc_ff[n] + prod[n][P-1:0];
               end
               if (i_ff == i1_ff) begin
                  if (j_ff == j1_ff) begin
                     k_ff     <= '0;
                     state_ff <= S_CH;
                  end else begin
                     j_ff     <= j_ff + 8'd1;
                     state_ff <= S_ROW;
                  end
               end else begin
                  i_ff     <= i_ff + 8'd1;
                  state_ff <= S_COLA;
               end
            end
            S_CH: state_ff <= S_DIV;
            S_CHQ: begin
               ch_ff[k_ff] <= div_quo_ff[CW-1:0];
               if (k_ff == 2'd3) begin
                  state_ff <= S_PACK;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_CH;
               end
            end
            S_PACK: begin
               res_color_ff <= color_in;
               res_alpha_ff <= alpha_in;
               state_ff     <= S_DONE;
            end
            // hand the word to the output register once it is free
            S_DONE: begin
               if (rsp_load) begin
                  rsp_color_ff <= res_color_ff;
                  rsp_alpha_ff <= res_alpha_ff;
                  rsp_oor_ff   <= res_oor_ff;
                  rsp_fw_ff    <= res_fw_ff;
                  rsp_fh_ff    <= res_fh_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.color_word    = rsp_color_ff;
   assign rsp_ch.alpha         = rsp_alpha_ff;
   assign rsp_ch.out_of_range  = rsp_oor_ff;
   assign rsp_ch.result_width  = rsp_fw_ff;
   assign rsp_ch.result_height = rsp_fh_ff;
endmodule
`default_nettype wire

[rtl/core/aas_ram.sv]
// Generic single write, single read RAM with registered read data
`default_nettype none
module aas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/core/aas_checker.sv]
// Port-level checks of the area average image scaler, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module aas_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_kind,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [aas_pkg::COLOR_W-1:0] rsp_color_word,
   input wire logic [aas_pkg::ALPHA_W-1:0] rsp_alpha,
   input wire logic                        rsp_out_of_range
);
   // output register is empty right after reset
   `AAS_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_valid, "response after reset")

   // a load never produces a word
   `AAS_ASSERT(a_load_no_rsp, clock, reset, req_valid && req_ready && (req_kind == aas_pkg::KIND_LOAD) && !rsp_valid |=> !rsp_valid, "load produced a response")

   // coordinates outside the frame carry no color
   `AAS_ASSERT(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range |-> (rsp_color_word == '0) && (rsp_alpha == '0), "out of range word not blank")

   // a stalled word stays offered
   `AAS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
endmodule

bind area_average_image_scaler aas_checker u_aas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_kind        (req_ch.kind),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_color_word  (rsp_ch.color_word),
   .rsp_alpha       (rsp_ch.alpha),
   .rsp_out_of_range(rsp_ch.out_of_range)
);
`default_nettype wire
